// ----- src/dbc_pkg.sv -----
// Package for the debounced button counter: widths, debounce constants,
// decimal split constants and the seven-segment decode function.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dbc_pkg;

    // Field and state widths.
    localparam int RAW_W    = 8;
    localparam int HIST_W   = 16;
    localparam int SUM_W    = 10;
    localparam int WEIGHT_W = 8;
    localparam int SEG_W    = 8;
    localparam int DIGIT_W  = 4;
    localparam int REM_W    = 7;

    // Debounce history constants.
    localparam logic [HIST_W-1:0] HIST_FORCE = 16'hE000;
    localparam logic [HIST_W-1:0] HIST_PRESS = 16'hF000;

    // Wrap limit of the sum.
    localparam logic [SUM_W-1:0] SUM_MAX = 10'd1023;

    // Decimal split: x / 100 == (x * 41) >> 12 for x below 1000, and
    // x / 10 == (x * 205) >> 11 for x below 1029.
    localparam logic [SUM_W-1:0] THOUSAND  = 10'd1000;
    localparam logic [SUM_W-1:0] HUNDRED   = 10'd100;
    localparam logic [REM_W-1:0] TEN       = 7'd10;
    localparam logic [15:0]      RECIP_100 = 16'd41;
    localparam logic [14:0]      RECIP_10  = 15'd205;

    // Load enables for the two decode stages.
    typedef struct packed {
        logic s2_load;
        logic s3_load;
    } t_pipe_en;

    // Active-low segment code of one decimal digit; bit 0 is segment a.
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] code;
        unique case (d)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = 8'hFF;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- src/debounced_button_counter_seven_segment.sv -----
// Debounced button counter with seven-segment decode, top level.
// An accepted word passes in turn through the sum, split and output registers.
// Throughput: one word per cycle; the three-stage pipeline (sum, split, decode)
// advances whenever its output register is empty or being taken.
// Reset (synchronous, active low) clears all histories, the sum and the
// pipeline valid flags. Depends on dbc_pkg, dbc_lane, dbc_merge, dbc_digits.
`default_nettype none

module debounced_button_counter_seven_segment #(
    parameter int BUTTON_COUNT = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [dbc_pkg::RAW_W-1:0]   i_raw_buttons_n,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [dbc_pkg::SUM_W-1:0]   o_running_sum,
    output logic      [dbc_pkg::SEG_W-1:0]   o_seg_units,
    output logic      [dbc_pkg::SEG_W-1:0]   o_seg_tens,
    output logic      [dbc_pkg::SEG_W-1:0]   o_seg_hundreds,
    output logic      [dbc_pkg::SEG_W-1:0]   o_seg_thousands,
    output logic                             o_press_seen
);

    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic                      n_v1;
    logic                      n_v2;
    logic                      n_v3;
    logic                      w_adv1;
    logic                      w_adv2;
    logic                      w_adv3;
    logic                      w_accept;
    dbc_pkg::t_pipe_en         w_en;
    logic [BUTTON_COUNT-1:0]   w_press;
    logic [dbc_pkg::SUM_W-1:0] w_sum;
    logic                      w_seen;

    // Pipeline flow: a stage may load when it is empty or moving on.
    always_comb begin
        w_adv3     = !r_v3 || !i_stall;
        w_adv2     = !r_v2 || w_adv3;
        w_adv1     = !r_v1 || w_adv2;
        w_accept   = i_valid && w_adv1;
        w_en.s2_load = w_adv2 && r_v1;
        w_en.s3_load = w_adv3 && r_v2;
        n_v1       = w_accept ? 1'b1 : (w_adv2 ? 1'b0 : r_v1);
        n_v2       = w_adv2 ? r_v1 : r_v2;
        n_v3       = w_adv3 ? r_v2 : r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    assign o_stall = !w_adv1;
    assign o_valid = r_v3;

    // One debounce lane per button.
    for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
        dbc_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (w_accept),
            .i_released (i_raw_buttons_n[g]),
            .o_press    (w_press[g])
        );
    end

    // Priority merge and running sum.
    dbc_merge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_press (w_press),
        .o_sum   (w_sum),
        .o_seen  (w_seen)
    );

    // Decimal split and segment decode.
    dbc_digits u_digits (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_sum           (w_sum),
        .i_seen          (w_seen),
        .o_running_sum   (o_running_sum),
        .o_seg_units     (o_seg_units),
        .o_seg_tens      (o_seg_tens),
        .o_seg_hundreds  (o_seg_hundreds),
        .o_seg_thousands (o_seg_thousands),
        .o_press_seen    (o_press_seen)
    );

endmodule

`default_nettype wire

// ----- src/dbc_lane.sv -----
// One debounce lane: the 16-bit shift history of a single button.
// Depends on dbc_pkg for the history constants.
`default_nettype none

module dbc_lane (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  wire logic i_released,
    output logic      o_press
);

    logic [dbc_pkg::HIST_W-1:0] r_hist;
    logic [dbc_pkg::HIST_W-1:0] n_hist;

    // Shift in the new level and force the top three bits high.
    always_comb begin
        n_hist  = {r_hist[dbc_pkg::HIST_W-2:0], i_released} | dbc_pkg::HIST_FORCE;
        o_press = (n_hist == dbc_pkg::HIST_PRESS);
    end

    // History register advances once per accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_load) begin
            r_hist <= n_hist;
        end
    end

endmodule

`default_nettype wire

// ----- src/dbc_merge.sv -----
// Merge stage: picks the highest-numbered lane that saw a press and
// updates the wrapping sum. Depends on dbc_pkg.
`default_nettype none

module dbc_merge #(
    parameter int BUTTON_COUNT = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_load,
    input  wire logic [BUTTON_COUNT-1:0]    i_press,
    output logic      [dbc_pkg::SUM_W-1:0]  o_sum,
    output logic                            o_seen
);

    logic [dbc_pkg::SUM_W-1:0]    r_sum;
    logic                         r_seen;
    logic [dbc_pkg::SUM_W-1:0]    n_sum;
    logic                         n_seen;
    logic [dbc_pkg::WEIGHT_W-1:0] w_weight;
    logic [dbc_pkg::SUM_W:0]      w_total;

    // Highest pressed lane wins: later loop passes override earlier ones.
    always_comb begin
        w_weight = '0;
        n_seen   = 1'b0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            if (i_press[i]) begin
                w_weight = dbc_pkg::WEIGHT_W'(1) << i;
                n_seen   = 1'b1;
            end
        end
    end

    // Add the weight and wrap once past the limit.
    always_comb begin
        w_total = {1'b0, r_sum} + (dbc_pkg::SUM_W+1)'(w_weight);
        if (w_total > (dbc_pkg::SUM_W+1)'(dbc_pkg::SUM_MAX)) begin
            w_total = w_total - (dbc_pkg::SUM_W+1)'(dbc_pkg::SUM_MAX);
        end
        n_sum = w_total[dbc_pkg::SUM_W-1:0];
    end

    // The sum is both the running state and the first pipeline stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_seen <= 1'b0;
        end else if (i_load) begin
            r_sum  <= n_sum;
            r_seen <= n_seen;
        end
    end

    assign o_sum  = r_sum;
    assign o_seen = r_seen;

endmodule

`default_nettype wire

// ----- src/dbc_digits.sv -----
// Two-stage decimal split and seven-segment decode of the sum.
// Stage two splits off thousands and hundreds, stage three tens and units.
// Depends on dbc_pkg.
`default_nettype none

module dbc_digits (
    input  wire logic                        i_clk,
    input  wire dbc_pkg::t_pipe_en           i_en,
    input  wire logic [dbc_pkg::SUM_W-1:0]   i_sum,
    input  wire logic                        i_seen,
    output logic      [dbc_pkg::SUM_W-1:0]   o_running_sum,
    output logic      [dbc_pkg::SEG_W-1:0]   o_seg_units,
    output logic      [dbc_pkg::SEG_W-1:0]   o_seg_tens,
    output logic      [dbc_pkg::SEG_W-1:0]   o_seg_hundreds,
    output logic      [dbc_pkg::SEG_W-1:0]   o_seg_thousands,
    output logic                             o_press_seen
);

    logic                          w_th;
    logic [dbc_pkg::SUM_W-1:0]     w_below_k;
    logic [15:0]                   w_hprod;
    logic [dbc_pkg::DIGIT_W-1:0]   w_hund;
    logic [dbc_pkg::SUM_W-1:0]     w_rem_wide;

    logic [dbc_pkg::SUM_W-1:0]     r_s2_sum;
    logic                          r_s2_seen;
    logic                          r_s2_th;
    logic [dbc_pkg::DIGIT_W-1:0]   r_s2_hund;
    logic [dbc_pkg::REM_W-1:0]     r_s2_rem;

    logic [14:0]                   w_tprod;
    logic [dbc_pkg::DIGIT_W-1:0]   w_tens;
    logic [dbc_pkg::REM_W-1:0]     w_unit_wide;

    // Thousands by compare, hundreds by reciprocal multiply.
    always_comb begin
        w_th       = (i_sum >= dbc_pkg::THOUSAND);
        w_below_k  = w_th ? (i_sum - dbc_pkg::THOUSAND) : i_sum;
        w_hprod    = 16'(w_below_k) * dbc_pkg::RECIP_100;
        w_hund     = w_hprod[15:12];
        w_rem_wide = w_below_k - dbc_pkg::SUM_W'(w_hund) * dbc_pkg::HUNDRED;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2_load) begin
            r_s2_sum  <= i_sum;
            r_s2_seen <= i_seen;
            r_s2_th   <= w_th;
            r_s2_hund <= w_hund;
            r_s2_rem  <= w_rem_wide[dbc_pkg::REM_W-1:0];
        end
    end

    // Tens by reciprocal multiply, units from the remainder.
    always_comb begin
        w_tprod     = 15'(r_s2_rem) * dbc_pkg::RECIP_10;
        w_tens      = w_tprod[14:11];
        w_unit_wide = r_s2_rem - dbc_pkg::REM_W'(w_tens) * dbc_pkg::TEN;
    end

    // Output register holds the finished word.
    always_ff @(posedge i_clk) begin
        if (i_en.s3_load) begin
            o_running_sum   <= r_s2_sum;
            o_press_seen    <= r_s2_seen;
            o_seg_thousands <= dbc_pkg::seg_code(dbc_pkg::DIGIT_W'(r_s2_th));
            o_seg_hundreds  <= dbc_pkg::seg_code(r_s2_hund);
            o_seg_tens      <= dbc_pkg::seg_code(w_tens);
            o_seg_units     <= dbc_pkg::seg_code(w_unit_wide[dbc_pkg::DIGIT_W-1:0]);
        end
    end

endmodule

`default_nettype wire

// ----- src/dbc_check.sv -----
// Port-level checker for the debounced button counter, bound to the top level.
// Depends on the top level's port names only.
`default_nettype none

module dbc_check (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [9:0] o_running_sum,
    input wire logic [7:0] o_seg_thousands
);

    // A stalled output word stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // The thousands digit can only show zero or one.
    a_thousands_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_seg_thousands == 8'hC0 || o_seg_thousands == 8'hF9))
        else $error("thousands digit out of range");

    // The thousands digit agrees with the binary sum.
    a_thousands_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_running_sum >= 10'd1000) == (o_seg_thousands == 8'hF9)))
        else $error("thousands digit disagrees with sum");

endmodule

bind debounced_button_counter_seven_segment dbc_check u_dbc_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_running_sum   (o_running_sum),
    .o_seg_thousands (o_seg_thousands)
);

`default_nettype wire

// ----- bench/debounced_button_counter_seven_segment_checker.sv -----
// Checker for the debounced button counter: watches both channels, predicts
// each display word from its own copy of the debounce histories and the sum.
// Depends on dbc_pkg for widths and the debounce constants.
`timescale 1ns / 100ps

module debounced_button_counter_seven_segment_checker #(
    parameter int BUTTONS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [dbc_pkg::RAW_W-1:0]   i_raw_buttons_n,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [dbc_pkg::SUM_W-1:0]   i_running_sum,
    input  logic [dbc_pkg::SEG_W-1:0]   i_seg_units,
    input  logic [dbc_pkg::SEG_W-1:0]   i_seg_tens,
    input  logic [dbc_pkg::SEG_W-1:0]   i_seg_hundreds,
    input  logic [dbc_pkg::SEG_W-1:0]   i_seg_thousands,
    input  logic                        i_press_seen,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_presses,
    output int                          o_wraps
);

    // One expected display word.
    typedef struct packed {
        logic [dbc_pkg::SUM_W-1:0] sum;
        logic [dbc_pkg::SEG_W-1:0] units;
        logic [dbc_pkg::SEG_W-1:0] tens;
        logic [dbc_pkg::SEG_W-1:0] hundreds;
        logic [dbc_pkg::SEG_W-1:0] thousands;
        logic                      seen;
    } t_display_word;

    // Predicted state of the block.
    logic [dbc_pkg::HIST_W-1:0] history [BUTTONS];
    logic [dbc_pkg::SUM_W-1:0]  tally;
    t_display_word              expected_display_q [$];

    int fail_count = 0;
    int checked    = 0;
    int presses    = 0;
    int wraps      = 0;

    // Active-low segment pattern of one decimal digit.
    function automatic logic [dbc_pkg::SEG_W-1:0] segments_for(input int digit);
        case (digit)
            0: return 8'hC0;
            1: return 8'hF9;
            2: return 8'hA4;
            3: return 8'hB0;
            4: return 8'h99;
            5: return 8'h92;
            6: return 8'h82;
            7: return 8'hF8;
            8: return 8'h80;
            9: return 8'h90;
            default: return 8'hFF;
        endcase
    endfunction

    // Advance every history by one sample and fold the winning press into the sum.
    function automatic t_display_word count_tick(input logic [dbc_pkg::RAW_W-1:0] raw);
        t_display_word              r;
        logic [dbc_pkg::HIST_W-1:0] h;
        logic [dbc_pkg::SUM_W-1:0]  weight;
        int                         total;
        weight = '0;
        r.seen = 1'b0;
        for (int b = 0; b < BUTTONS; b++) begin
            h = {history[b][dbc_pkg::HIST_W-2:0], raw[b]} | dbc_pkg::HIST_FORCE;
            history[b] = h;
            // Later buttons overwrite earlier ones, so the highest wins.
            if (h == dbc_pkg::HIST_PRESS) begin
                weight = dbc_pkg::SUM_W'(1 << b);
                r.seen = 1'b1;
            end
        end
        total = int'(tally) + int'(weight);
        if (total > 1023) begin
            total = total - 1023;
            wraps++;
        end
        if (r.seen) presses++;
        tally       = dbc_pkg::SUM_W'(total);
        r.sum       = tally;
        r.units     = segments_for(total % 10);
        r.tens      = segments_for((total / 10) % 10);
        r.hundreds  = segments_for((total / 100) % 10);
        r.thousands = segments_for((total / 1000) % 10);
        return r;
    endfunction

    task automatic check_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    // Compare taken words against the oldest prediction, then predict new ones.
    always @(posedge i_clk) begin
        t_display_word want;
        if (!i_rst_n) begin
            for (int b = 0; b < BUTTONS; b++) history[b] = '0;
            tally = '0;
            expected_display_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_display_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none, got sum %0d",
                             $time, i_running_sum);
                end else begin
                    want = expected_display_q.pop_front();
                    checked++;
                    check_field("running_sum", want.sum, i_running_sum);
                    check_field("seg_units", want.units, i_seg_units);
                    check_field("seg_tens", want.tens, i_seg_tens);
                    check_field("seg_hundreds", want.hundreds, i_seg_hundreds);
                    check_field("seg_thousands", want.thousands, i_seg_thousands);
                    check_field("press_seen", want.seen, i_press_seen);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_display_q.push_back(count_tick(i_raw_buttons_n));
            end
        end
        o_pending    <= expected_display_q.size();
        o_fail_count <= fail_count;
        o_checked    <= checked;
        o_presses    <= presses;
        o_wraps      <= wraps;
    end

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        o_checked    = 0;
        o_presses    = 0;
        o_wraps      = 0;
    end

endmodule

// ----- bench/debounced_button_counter_seven_segment_tb.sv -----
// Testbench top for the debounced button counter: drives button words with
// random gaps and output stalls, and reports the checker's verdict.
// Depends on dbc_pkg, the block and debounced_button_counter_seven_segment_checker.
`timescale 1ns / 100ps

module debounced_button_counter_seven_segment_tb;

    localparam int BUTTONS     = 8;
    localparam int WORD_TARGET = 1477;
    localparam int QUIET_START = 600;
    localparam int QUIET_END   = 800;
    localparam int STUCK_LIMIT = 2000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [dbc_pkg::RAW_W-1:0]   i_raw_buttons_n;
    logic                        o_valid;
    logic                        i_stall;
    logic [dbc_pkg::SUM_W-1:0]   o_running_sum;
    logic [dbc_pkg::SEG_W-1:0]   o_seg_units;
    logic [dbc_pkg::SEG_W-1:0]   o_seg_tens;
    logic [dbc_pkg::SEG_W-1:0]   o_seg_hundreds;
    logic [dbc_pkg::SEG_W-1:0]   o_seg_thousands;
    logic                        o_press_seen;

    int fail_count;
    int pending_words;
    int checked_words;
    int press_count;
    int wrap_count;
    int words_sent = 0;
    int stuck_cycles = 0;

    debounced_button_counter_seven_segment #(
        .BUTTON_COUNT(BUTTONS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_raw_buttons_n (i_raw_buttons_n),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_running_sum   (o_running_sum),
        .o_seg_units     (o_seg_units),
        .o_seg_tens      (o_seg_tens),
        .o_seg_hundreds  (o_seg_hundreds),
        .o_seg_thousands (o_seg_thousands),
        .o_press_seen    (o_press_seen)
    );

    debounced_button_counter_seven_segment_checker #(
        .BUTTONS(BUTTONS)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_raw_buttons_n (i_raw_buttons_n),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_running_sum   (o_running_sum),
        .i_seg_units     (o_seg_units),
        .i_seg_tens      (o_seg_tens),
        .i_seg_hundreds  (o_seg_hundreds),
        .i_seg_thousands (o_seg_thousands),
        .i_press_seen    (o_press_seen),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words),
        .o_checked       (checked_words),
        .o_presses       (press_count),
        .o_wraps         (wrap_count)
    );

    always #5 i_clk = ~i_clk;

    // Random idling, switched off for one stretch of the run.
    function automatic logic idle_now();
        if (words_sent >= QUIET_START && words_sent < QUIET_END) return 1'b0;
        return $urandom_range(0, 99) < 38;
    endfunction

    // The output side stalls at random.
    always @(negedge i_clk) begin
        i_stall <= idle_now();
    end

    // Watchdog: end the run when no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Watchdog expired at %0t with %0d words pending.", $time, pending_words);
            $display("[debounced_button_counter_seven_segment] ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Offer one button word, with random gaps first, and hold it until taken.
    task automatic send_word(input logic [dbc_pkg::RAW_W-1:0] w);
        @(negedge i_clk);
        while (idle_now()) begin
            i_valid         <= 1'b0;
            i_raw_buttons_n <= dbc_pkg::RAW_W'($urandom);
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_raw_buttons_n <= w;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
    endtask

    // One release sample and then a press run on a set of buttons, sometimes
    // held longer and sometimes broken by a bounce; other buttons are noise.
    task automatic press_burst();
        logic [dbc_pkg::RAW_W-1:0] held;
        logic [dbc_pkg::RAW_W-1:0] w;
        int                        hold_len;
        int                        bounce_at;
        if ($urandom_range(0, 1) != 0) begin
            held = dbc_pkg::RAW_W'(1 << $urandom_range(0, BUTTONS - 1));
        end else begin
            held = dbc_pkg::RAW_W'($urandom_range(1, 255));
        end
        hold_len  = ($urandom_range(0, 3) == 0) ? 12 + $urandom_range(1, 6) : 12;
        bounce_at = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 11) : 0;
        w = dbc_pkg::RAW_W'($urandom) | held;
        send_word(w);
        for (int t = 1; t <= hold_len; t++) begin
            w = dbc_pkg::RAW_W'($urandom) & ~held;
            if (t == bounce_at) w = w | held;
            send_word(w);
        end
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_raw_buttons_n = '1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All buttons pressed straight from reset never count, since no
        // release was seen; then every button presses on the same tick.
        send_word(8'h00);
        send_word(8'hFF);
        repeat (12) send_word(8'h00);
        // Button 0 alone, with all others released.
        send_word(8'hFF);
        repeat (12) send_word(8'hFE);

        // Mostly well-formed press runs, the rest plain noise.
        while (words_sent < WORD_TARGET) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 8)) send_word(dbc_pkg::RAW_W'($urandom));
            end else begin
                press_burst();
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending_words == 0);
        repeat (12) @(posedge i_clk);

        $display("Sent %0d button words and checked %0d display words.",
                 words_sent, checked_words);
        $display("Debounced presses: %0d, sum wraps: %0d, failures: %0d.",
                 press_count, wrap_count, fail_count);
        if (fail_count == 0) begin
            $display("[debounced_button_counter_seven_segment] OK");
        end else begin
            $display("[debounced_button_counter_seven_segment] ERROR");
        end
        $finish;
    end

endmodule
